### design/halfpel_motion_compensation_store_top_defines.svh
// Assertion macros shared by the checker of the half-pel prediction block.
`ifndef HALFPEL_MOTION_COMPENSATION_STORE_TOP_DEFINES_SVH
`define HALFPEL_MOTION_COMPENSATION_STORE_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HPMC_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hpmc assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define HPMC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hpmc assertion failed");

`endif

### design/hpmc_pkg.sv
// Package with the types, constants and helpers of the half-pel prediction block.
`default_nettype none
package hpmc_pkg;

    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HEIGHT_DEF = 1024;

    localparam int DIM_W    = 11;
    localparam int MBI_W    = 12;
    localparam int BLK_W    = 3;
    localparam int POS_W    = 6;
    localparam int SMP_W    = 8;
    localparam int MV_W     = 13;
    localparam int COORD_W  = 20;
    localparam int ACC_W    = 10;
    localparam int MBW_W    = 7;
    localparam int DIV_CNT_W = 4;

    localparam int S_DATA_W = 56;
    localparam int M_DATA_W = 16;
    localparam int APB_AW   = 3;
    localparam int APB_DW   = 32;

    localparam logic [BLK_W-1:0] BLK_CB = 3'd4;
    localparam logic [BLK_W-1:0] BLK_CR = 3'd5;
    localparam logic             REG_WIDTH  = 1'b0;
    localparam logic             REG_HEIGHT = 1'b1;
    localparam logic             MODE_WRITE = 1'b0;
    localparam logic [POS_W-1:0] LAST_POS   = 6'd63;
    localparam logic [DIV_CNT_W-1:0] DIV_LAST = 4'(MBI_W - 1);

    localparam logic [DIM_W-1:0] FRAME_WIDTH_RST  = 11'd720;
    localparam logic [DIM_W-1:0] FRAME_HEIGHT_RST = 11'd576;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DIV,
        ST_SETUP,
        ST_WRITE,
        ST_READ,
        ST_ACC,
        ST_OUT
    } state_t;

    typedef enum logic [1:0] {
        PLANE_LUMA,
        PLANE_CB,
        PLANE_CR
    } plane_t;

    // Round the low eleven bits down to a multiple of sixteen and limit to sixteen..maxv.
    function automatic logic [DIM_W-1:0] fit_dim(input logic [APB_DW-1:0] v,
                                                 input logic [12:0] maxv);
        logic [DIM_W-1:0] d;
        d = {v[10:4], 4'b0000};
        if (d < 11'd16) d = 11'd16;
        if ({2'b00, d} > maxv) d = maxv[DIM_W-1:0];
        return d;
    endfunction

endpackage
`default_nettype wire

### design/halfpel_motion_compensation_store_top.sv
// Top level of the half-pel motion-compensated prediction block with its frame store.
//
//  Channel   Role            Contents
//  s_*       item in         tuser = mode, tdata = block and vector fields
//  m_*       result out      tdata = sample and position, tuser = clamp flag, tlast
//  p*        register port   frame_width at 0x0, frame_height at 0x4
//
// After reset the three sample memories are cleared one entry per cycle, and no
// item is taken during this sweep. Each item with a block select up to five starts
// with a twelve-step shared restoring divider that splits the macroblock number
// into column and row. A write then passes through a setup state and a write state.
// A prediction visits, per sample, each of the four tap positions in a read state,
// adds an accumulate state per tap actually read, since all reads go through one
// memory read port, and ends in an output state that holds while the output stalls.
// The block takes one item at a time; s_tready is high only when idle.
`default_nettype none
module halfpel_motion_compensation_store_top #(
    parameter int MAX_WIDTH  = hpmc_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = hpmc_pkg::MAX_HEIGHT_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // mbi[11:0], block_select[14:12], sample_position[20:15],
    // sample_value[28:21], motion_x[41:29], motion_y[54:42], zero pad
    input  wire logic [hpmc_pkg::S_DATA_W-1:0] s_tdata,
    // mode
    input  wire logic                          s_tuser,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // predicted_sample[7:0], out_position[13:8], zero pad
    output logic [hpmc_pkg::M_DATA_W-1:0]      m_tdata,
    // outside_frame
    output logic                               m_tuser,
    output logic                               m_tlast,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [hpmc_pkg::APB_AW-1:0]   paddr,
    input  wire logic [hpmc_pkg::APB_DW-1:0]   pwdata,
    output logic [hpmc_pkg::APB_DW-1:0]        prdata,
    output logic                               pready
);
    import hpmc_pkg::*;

    localparam int LUMA_DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int CH_PITCH   = MAX_WIDTH / 2;
    localparam int CH_DEPTH   = (MAX_WIDTH / 2) * (MAX_HEIGHT / 2);
    localparam int LA_W       = $clog2(LUMA_DEPTH);
    localparam int CA_W       = $clog2(CH_DEPTH);

    // Configuration registers, stored already fitted to the legal range.
    logic [DIM_W-1:0] fw_reg, fw_next, fh_reg, fh_next;
    logic             cfg_we;

    state_t state_reg, state_next;

    logic [LA_W-1:0]      clr_cnt_reg, clr_cnt_next;
    logic [DIV_CNT_W-1:0] div_cnt_reg, div_cnt_next;
    logic [MBW_W-1:0]     rem_reg, rem_next;
    logic [MBI_W-1:0]     quo_reg, quo_next;

    logic              mode_reg, mode_next;
    logic [BLK_W-1:0]  blk_reg, blk_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [SMP_W-1:0]  val_reg, val_next;
    logic signed [MV_W-1:0] mx_reg, mx_next, my_reg, my_next;

    logic signed [COORD_W-1:0] bx_reg, bx_next, by_reg, by_next;
    logic [DIM_W-1:0] w_reg, w_next, h_reg, h_next;
    logic hx_reg, hx_next, hy_reg, hy_next;
    plane_t plane_reg, plane_next;

    logic [POS_W-1:0] n_reg, n_next;
    logic [1:0]       tap_reg, tap_next;
    logic [ACC_W-1:0] acc_reg, acc_next;
    logic             cl_reg, cl_next;

    logic [SMP_W-1:0] luma_rd_reg, cb_rd_reg, cr_rd_reg;
    logic [SMP_W-1:0] rd_data;

    logic [SMP_W-1:0] luma_mem [LUMA_DEPTH];
    logic [SMP_W-1:0] cb_mem   [CH_DEPTH];
    logic [SMP_W-1:0] cr_mem   [CH_DEPTH];

    // Divider step.
    logic [MBW_W-1:0] mbw;
    logic [MBW_W:0]   trial;
    logic             ge;

    // Setup of block base, vector and plane.
    logic signed [MV_W-1:0]    vx, vy;
    logic signed [COORD_W-1:0] base_x, base_y, sx, sy;
    logic [DIM_W-1:0]          pw, ph;
    logic                      chroma;

    // Shared coordinate, clamp and address unit.
    logic [3:0]                colv, rowv;
    logic signed [COORD_W-1:0] cx, cy;
    logic                      x_lo, x_hi, y_lo, y_hi, clamp_now;
    logic [DIM_W-1:0]          xc, yc;
    logic [LA_W-1:0]           luma_addr, luma_waddr;
    logic [CA_W-1:0]           ch_addr, ch_waddr;
    logic                      luma_we, cb_we, cr_we, clr_ch;
    logic [SMP_W-1:0]          wdata;
    logic                      tap_en;
    logic [ACC_W-1:0]          rnd;

    // ---------------- configuration port ----------------
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && pready;
    assign prdata = (paddr[2] == REG_HEIGHT) ? {21'b0, fh_reg} : {21'b0, fw_reg};

    always_comb
    begin
        fw_next = fw_reg;
        fh_next = fh_reg;
        if (cfg_we)
        begin
            if (paddr[2] == REG_WIDTH)
                fw_next = fit_dim(pwdata, 13'(MAX_WIDTH));
            else
                fh_next = fit_dim(pwdata, 13'(MAX_HEIGHT));
        end
    end

    // ---------------- shared divider step ----------------
    // Macroblocks per row; a fitted width is at least sixteen, so this is never zero.
    assign mbw   = fw_reg[DIM_W-1:4];
    assign trial = {rem_reg, quo_reg[MBI_W-1]};
    assign ge    = trial >= {1'b0, mbw};

    // ---------------- block setup ----------------
    always_comb
    begin
        chroma = (blk_reg == BLK_CB) || (blk_reg == BLK_CR);
        if (chroma)
        begin
            // Chroma vectors are halved toward zero.
            vx     = $signed(mx_reg + MV_W'(mx_reg[MV_W-1])) >>> 1;
            vy     = $signed(my_reg + MV_W'(my_reg[MV_W-1])) >>> 1;
            base_x = $signed({10'b0, rem_reg, 3'b000});
            base_y = $signed({5'b0, quo_reg, 3'b000});
            pw     = {1'b0, fw_reg[DIM_W-1:1]};
            ph     = {1'b0, fh_reg[DIM_W-1:1]};
        end
        else
        begin
            vx     = mx_reg;
            vy     = my_reg;
            base_x = $signed({9'b0, rem_reg, blk_reg[0], 3'b000});
            base_y = $signed({4'b0, quo_reg, blk_reg[1], 3'b000});
            pw     = fw_reg;
            ph     = fh_reg;
        end
        if (mode_reg == MODE_WRITE)
        begin
            sx = base_x;
            sy = base_y;
        end
        else
        begin
            sx = base_x + COORD_W'(vx >>> 1);
            sy = base_y + COORD_W'(vy >>> 1);
        end
    end

    // ---------------- coordinate, clamp and address ----------------
    always_comb
    begin
        if (mode_reg == MODE_WRITE)
        begin
            colv = {1'b0, pos_reg[2:0]};
            rowv = {1'b0, pos_reg[5:3]};
        end
        else
        begin
            colv = {1'b0, n_reg[2:0]} + {3'b0, tap_reg[0]};
            rowv = {1'b0, n_reg[5:3]} + {3'b0, tap_reg[1]};
        end
        cx   = bx_reg + $signed({16'b0, colv});
        cy   = by_reg + $signed({16'b0, rowv});
        x_lo = cx[COORD_W-1];
        y_lo = cy[COORD_W-1];
        x_hi = !x_lo && (cx >= $signed({9'b0, w_reg}));
        y_hi = !y_lo && (cy >= $signed({9'b0, h_reg}));
        clamp_now = x_lo || x_hi || y_lo || y_hi;
        xc = x_lo ? '0 : (x_hi ? w_reg - 11'd1 : cx[DIM_W-1:0]);
        yc = y_lo ? '0 : (y_hi ? h_reg - 11'd1 : cy[DIM_W-1:0]);
        luma_addr = LA_W'(yc) * LA_W'(MAX_WIDTH) + LA_W'(xc);
        ch_addr   = CA_W'(yc) * CA_W'(CH_PITCH) + CA_W'(xc);
        tap_en = (!tap_reg[0] || hx_reg) && (!tap_reg[1] || hy_reg);
    end

    // Memory write side: the clearing sweep, or one stored sample.
    always_comb
    begin
        clr_ch     = (state_reg == ST_CLEAR) && (32'(clr_cnt_reg) < CH_DEPTH);
        luma_waddr = (state_reg == ST_CLEAR) ? clr_cnt_reg : luma_addr;
        ch_waddr   = (state_reg == ST_CLEAR) ? CA_W'(clr_cnt_reg) : ch_addr;
        wdata      = (state_reg == ST_CLEAR) ? '0 : val_reg;
        luma_we    = (state_reg == ST_CLEAR) ||
                     ((state_reg == ST_WRITE) && !clamp_now && (plane_reg == PLANE_LUMA));
        cb_we      = clr_ch ||
                     ((state_reg == ST_WRITE) && !clamp_now && (plane_reg == PLANE_CB));
        cr_we      = clr_ch ||
                     ((state_reg == ST_WRITE) && !clamp_now && (plane_reg == PLANE_CR));
    end

    always_ff @(posedge clk)
    begin
        if (luma_we)
            luma_mem[luma_waddr] <= wdata;
        luma_rd_reg <= luma_mem[luma_addr];
    end

    always_ff @(posedge clk)
    begin
        if (cb_we)
            cb_mem[ch_waddr] <= wdata;
        cb_rd_reg <= cb_mem[ch_addr];
    end

    always_ff @(posedge clk)
    begin
        if (cr_we)
            cr_mem[ch_waddr] <= wdata;
        cr_rd_reg <= cr_mem[ch_addr];
    end

    always_comb
    begin
        case (plane_reg)
            PLANE_CB: rd_data = cb_rd_reg;
            PLANE_CR: rd_data = cr_rd_reg;
            default:  rd_data = luma_rd_reg;
        endcase
    end

    // ---------------- next state ----------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
                if (32'(clr_cnt_reg) == LUMA_DEPTH - 1)
                    state_next = ST_IDLE;
            ST_IDLE:
                if (s_tvalid && (s_tdata[14:12] <= BLK_CR))
                    state_next = ST_DIV;
            ST_DIV:
                if (div_cnt_reg == DIV_LAST)
                    state_next = ST_SETUP;
            ST_SETUP:
                state_next = (mode_reg == MODE_WRITE) ? ST_WRITE : ST_READ;
            ST_WRITE:
                state_next = ST_IDLE;
            ST_READ:
                if (tap_en)
                    state_next = ST_ACC;
                else if (tap_reg == 2'd3)
                    state_next = ST_OUT;
            ST_ACC:
                state_next = (tap_reg == 2'd3) ? ST_OUT : ST_READ;
            ST_OUT:
                if (m_tready)
                    state_next = (n_reg == LAST_POS) ? ST_IDLE : ST_READ;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // ---------------- datapath next values ----------------
    always_comb
    begin
        clr_cnt_next = clr_cnt_reg;
        div_cnt_next = div_cnt_reg;
        rem_next     = rem_reg;
        quo_next     = quo_reg;
        mode_next    = mode_reg;
        blk_next     = blk_reg;
        pos_next     = pos_reg;
        val_next     = val_reg;
        mx_next      = mx_reg;
        my_next      = my_reg;
        bx_next      = bx_reg;
        by_next      = by_reg;
        w_next       = w_reg;
        h_next       = h_reg;
        hx_next      = hx_reg;
        hy_next      = hy_reg;
        plane_next   = plane_reg;
        n_next       = n_reg;
        tap_next     = tap_reg;
        acc_next     = acc_reg;
        cl_next      = cl_reg;
        case (state_reg)
            ST_CLEAR:
                clr_cnt_next = clr_cnt_reg + 1'b1;
            ST_IDLE:
            begin
                mode_next    = s_tuser;
                blk_next     = s_tdata[14:12];
                pos_next     = s_tdata[20:15];
                val_next     = s_tdata[28:21];
                mx_next      = $signed(s_tdata[41:29]);
                my_next      = $signed(s_tdata[54:42]);
                rem_next     = '0;
                quo_next     = s_tdata[11:0];
                div_cnt_next = '0;
            end
            ST_DIV:
            begin
                rem_next     = ge ? MBW_W'(trial - {1'b0, mbw}) : trial[MBW_W-1:0];
                quo_next     = {quo_reg[MBI_W-2:0], ge};
                div_cnt_next = div_cnt_reg + 1'b1;
            end
            ST_SETUP:
            begin
                bx_next = sx;
                by_next = sy;
                w_next  = pw;
                h_next  = ph;
                // Interpolation is off where the block reaches the right or bottom edge.
                hx_next = (mode_reg != MODE_WRITE) && vx[0] &&
                          !(sx + 20'sd8 >= $signed({9'b0, pw}));
                hy_next = (mode_reg != MODE_WRITE) && vy[0] &&
                          !(sy + 20'sd8 >= $signed({9'b0, ph}));
                if (blk_reg == BLK_CB)
                    plane_next = PLANE_CB;
                else if (blk_reg == BLK_CR)
                    plane_next = PLANE_CR;
                else
                    plane_next = PLANE_LUMA;
                n_next   = '0;
                tap_next = '0;
                acc_next = '0;
                cl_next  = 1'b0;
            end
            ST_READ:
            begin
                if (tap_en)
                    cl_next = cl_reg || clamp_now;
                else if (tap_reg != 2'd3)
                    tap_next = tap_reg + 1'b1;
            end
            ST_ACC:
            begin
                acc_next = acc_reg + ACC_W'(rd_data);
                if (tap_reg != 2'd3)
                    tap_next = tap_reg + 1'b1;
            end
            ST_OUT:
                if (m_tready)
                begin
                    n_next   = n_reg + 1'b1;
                    tap_next = '0;
                    acc_next = '0;
                    cl_next  = 1'b0;
                end
            default:
            begin
            end
        endcase
    end

    // ---------------- outputs ----------------
    always_comb
    begin
        case ({hx_reg, hy_reg})
            2'b11:   rnd = (acc_reg + 10'd2) >> 2;
            2'b10,
            2'b01:   rnd = (acc_reg + 10'd1) >> 1;
            default: rnd = acc_reg;
        endcase
        s_tready = (state_reg == ST_IDLE);
        m_tvalid = (state_reg == ST_OUT);
        m_tdata  = {2'b00, n_reg, rnd[SMP_W-1:0]};
        m_tuser  = cl_reg;
        m_tlast  = (n_reg == LAST_POS);
    end

    // ---------------- registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
            fw_reg      <= FRAME_WIDTH_RST;
            fh_reg      <= FRAME_HEIGHT_RST;
            div_cnt_reg <= '0;
            n_reg       <= '0;
            tap_reg     <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            fw_reg      <= fw_next;
            fh_reg      <= fh_next;
            div_cnt_reg <= div_cnt_next;
            n_reg       <= n_next;
            tap_reg     <= tap_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg   <= rem_next;
        quo_reg   <= quo_next;
        mode_reg  <= mode_next;
        blk_reg   <= blk_next;
        pos_reg   <= pos_next;
        val_reg   <= val_next;
        mx_reg    <= mx_next;
        my_reg    <= my_next;
        bx_reg    <= bx_next;
        by_reg    <= by_next;
        w_reg     <= w_next;
        h_reg     <= h_next;
        hx_reg    <= hx_next;
        hy_reg    <= hy_next;
        plane_reg <= plane_next;
        acc_reg   <= acc_next;
        cl_reg    <= cl_next;
    end

endmodule
`default_nettype wire

### design/hpmc_checker.sv
// Port-level checker of the half-pel prediction block and its bind statement.
`default_nettype none
`include "halfpel_motion_compensation_store_top_defines.svh"
module hpmc_checker (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          s_tready,
    input wire logic                          m_tvalid,
    input wire logic                          m_tready,
    input wire logic [hpmc_pkg::M_DATA_W-1:0] m_tdata,
    input wire logic                          m_tlast
);
    // A stalled result keeps its value.
    `HPMC_ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
    // One item at a time: no new item is taken while a result is shown.
    `HPMC_ASSERT_SAME(a_busy_out, clk, rst_n, m_tvalid, !s_tready)
    // After the last sample of a block, the output goes quiet.
    `HPMC_ASSERT_NEXT(a_last_end, clk, rst_n, m_tvalid && m_tready && m_tlast, !m_tvalid)
    // Within a block, the block stays busy after each sample.
    `HPMC_ASSERT_NEXT(a_mid_busy, clk, rst_n, m_tvalid && m_tready && !m_tlast, !s_tready)
endmodule

bind halfpel_motion_compensation_store_top hpmc_checker u_hpmc_checker (.*);
`default_nettype wire

### tb/tb_top.sv
// Self-checking testbench of the half-pel motion-compensated prediction block.
`timescale 1ns / 1ps
module tb_top;
    import hpmc_pkg::*;

    localparam logic            MODE_PRED   = ~MODE_WRITE;
    localparam logic [APB_AW-1:0] ADDR_WIDTH  = 3'h0;
    localparam logic [APB_AW-1:0] ADDR_HEIGHT = 3'h4;
    localparam int LUMA_PITCH   = MAX_WIDTH_DEF;
    localparam int CHROMA_PITCH = MAX_WIDTH_DEF / 2;
    // The limit covers the clearing sweep, with generous slack for the rest.
    localparam int CYCLE_LIMIT  = 4_000_000;

    typedef struct {
        logic [SMP_W-1:0] smp;
        logic [POS_W-1:0] pos;
        logic             last;
        logic             outside;
    } sample_t;

    typedef struct {
        logic             mode;
        logic [MBI_W-1:0] mbi;
        logic [BLK_W-1:0] blk;
        logic [POS_W-1:0] pos;
        logic [SMP_W-1:0] val;
        logic [MV_W-1:0]  mvx;
        logic [MV_W-1:0]  mvy;
        bit               known;
        logic [SMP_W-1:0] known_smp;
        logic             known_out;
    } item_t;

    logic                clk;
    logic                rst_n;
    logic                s_tvalid;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata;
    logic                s_tuser;
    logic                m_tvalid;
    logic                m_tready;
    logic [M_DATA_W-1:0] m_tdata;
    logic                m_tuser;
    logic                m_tlast;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [APB_AW-1:0]   paddr;
    logic [APB_DW-1:0]   pwdata;
    logic [APB_DW-1:0]   prdata;
    logic                pready;

    halfpel_motion_compensation_store_top u_dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .m_tlast(m_tlast),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // Shadow frame store: sparse, entries never written read as zero.
    logic [7:0] luma_mem [int];
    logic [7:0] cb_mem   [int];
    logic [7:0] cr_mem   [int];
    int         frame_w;
    int         frame_h;

    sample_t    pending_samples[$];
    item_t      directed_items[$];
    int         errors;
    int         cycles;
    bit         idle_en;
    int         rdy_hold;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic int fit_dim(logic [APB_DW-1:0] v);
        int d;
        d = int'({v[10:4], 4'b0000});
        if (d < 16) d = 16;
        if (d > 1024) d = 1024;
        return d;
    endfunction

    function automatic int fetch(int plane, int w, int h, int x, int y, inout bit cl);
        int addr;
        if (x < 0) begin x = 0; cl = 1; end
        if (x > w - 1) begin x = w - 1; cl = 1; end
        if (y < 0) begin y = 0; cl = 1; end
        if (y > h - 1) begin y = h - 1; cl = 1; end
        if (plane == PLANE_LUMA)
        begin
            addr = y * LUMA_PITCH + x;
            return luma_mem.exists(addr) ? int'(luma_mem[addr]) : 0;
        end
        addr = y * CHROMA_PITCH + x;
        if (plane == PLANE_CB)
            return cb_mem.exists(addr) ? int'(cb_mem[addr]) : 0;
        return cr_mem.exists(addr) ? int'(cr_mem[addr]) : 0;
    endfunction

    // Updates the shadow store for a write, or queues the 64 predicted samples.
    function automatic void predict_block(item_t it);
        int mbw, xi, yi, w, h, bx, by, vx, vy, x, y, s, p, plane, pitch, n;
        bit hx, hy, cl;
        sample_t r;
        mbw = frame_w / 16;
        xi = int'(it.mbi) % mbw;
        yi = int'(it.mbi) / mbw;
        if (it.blk > BLK_CR) return;
        if (it.blk < BLK_CB)
        begin
            plane = PLANE_LUMA;
            pitch = LUMA_PITCH;
            w = frame_w;
            h = frame_h;
            bx = xi * 16 + (it.blk[0] ? 8 : 0);
            by = yi * 16 + (it.blk[1] ? 8 : 0);
            vx = int'($signed(it.mvx));
            vy = int'($signed(it.mvy));
        end
        else
        begin
            plane = (it.blk == BLK_CB) ? PLANE_CB : PLANE_CR;
            pitch = CHROMA_PITCH;
            w = frame_w / 2;
            h = frame_h / 2;
            bx = xi * 8;
            by = yi * 8;
            vx = int'($signed(it.mvx)) / 2;
            vy = int'($signed(it.mvy)) / 2;
        end
        if (it.mode == MODE_WRITE)
        begin
            x = bx + int'(it.pos[2:0]);
            y = by + int'(it.pos[5:3]);
            if (x < w && y < h)
            begin
                if (plane == PLANE_LUMA) luma_mem[y * pitch + x] = it.val;
                else if (plane == PLANE_CB) cb_mem[y * pitch + x] = it.val;
                else cr_mem[y * pitch + x] = it.val;
            end
            return;
        end
        hx = vx[0];
        hy = vy[0];
        bx += vx >>> 1;
        by += vy >>> 1;
        if (bx + 8 >= w) hx = 0;
        if (by + 8 >= h) hy = 0;
        for (n = 0; n < 64; n++)
        begin
            x = bx + (n % 8);
            y = by + n / 8;
            cl = 0;
            s = fetch(plane, w, h, x, y, cl);
            if (hx && hy)
            begin
                s += fetch(plane, w, h, x + 1, y, cl);
                s += fetch(plane, w, h, x, y + 1, cl);
                s += fetch(plane, w, h, x + 1, y + 1, cl);
                p = (s + 2) >> 2;
            end
            else if (hx || hy)
            begin
                s += hx ? fetch(plane, w, h, x + 1, y, cl) : fetch(plane, w, h, x, y + 1, cl);
                p = (s + 1) >> 1;
            end
            else
                p = s;
            r.smp = p[7:0];
            r.pos = n[5:0];
            r.last = (n == 63);
            r.outside = cl;
            pending_samples.push_back(r);
        end
    endfunction

    function automatic item_t mk(logic mode, int mbi, int blk, int pos, int val,
                                 int mvx, int mvy, bit known, int ksmp, bit kout);
        item_t it;
        it.mode = mode;
        it.mbi = mbi[MBI_W-1:0];
        it.blk = blk[BLK_W-1:0];
        it.pos = pos[POS_W-1:0];
        it.val = val[SMP_W-1:0];
        it.mvx = mvx[MV_W-1:0];
        it.mvy = mvy[MV_W-1:0];
        it.known = known;
        it.known_smp = ksmp[SMP_W-1:0];
        it.known_out = kout;
        return it;
    endfunction

    // Present one item, optionally after a random gap, and log its expectations
    // at the edge where it is taken. Valid stays high on return.
    task automatic send_item(item_t it);
        sample_t r;
        if (idle_en && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= it.mode;
        s_tdata <= {1'b0, it.mvy, it.mvx, it.val, it.pos, it.blk, it.mbi};
        do @(posedge clk); while (!s_tready);
        if (it.known && it.mode == MODE_PRED)
        begin
            for (int n = 0; n < 64; n++)
            begin
                r.smp = it.known_smp;
                r.pos = n[5:0];
                r.last = (n == 63);
                r.outside = it.known_out;
                pending_samples.push_back(r);
            end
        end
        else
            predict_block(it);
    endtask

    // Drains all results, then lets a trailing write item finish.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending_samples.size() != 0) @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic reg_write(logic [APB_AW-1:0] addr, logic [APB_DW-1:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
        if (addr == ADDR_WIDTH) frame_w = fit_dim(data);
        else frame_h = fit_dim(data);
    endtask

    // Random item: mostly in-frame traffic on a few macroblocks so that
    // predictions read back written samples, with some full-range noise.
    function automatic item_t rand_item();
        item_t it;
        int nmb;
        nmb = (frame_w / 16) * (frame_h / 16);
        if ($urandom_range(0, 6) == 0)
        begin
            it = mk($urandom_range(0, 1), $urandom, $urandom_range(0, 7), $urandom,
                    $urandom, $urandom, $urandom, 0, 0, 0);
        end
        else
        begin
            it = mk(($urandom_range(0, 9) < 6) ? MODE_WRITE : MODE_PRED,
                    $urandom_range(0, (nmb < 6) ? nmb - 1 : 5), $urandom_range(0, 5),
                    $urandom, $urandom, 0, 0, 0, 0, 0);
            if ($urandom_range(0, 4) == 0)
            begin
                it.mvx = $urandom;
                it.mvy = $urandom;
            end
            else
            begin
                it.mvx = MV_W'($urandom_range(0, 40) - 20);
                it.mvy = MV_W'($urandom_range(0, 40) - 20);
            end
        end
        return it;
    endfunction

    // Result checker: every taken result is matched against the oldest expectation.
    always @(posedge clk)
    begin
        sample_t e;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_samples.size() == 0)
            begin
                $display("%0t: unexpected result tdata=%h tuser=%b tlast=%b",
                         $realtime, m_tdata, m_tuser, m_tlast);
                errors++;
            end
            else
            begin
                e = pending_samples.pop_front();
                if (m_tdata[7:0] !== e.smp)
                begin
                    $display("%0t: sample expected %0d actual %0d", $realtime, e.smp, m_tdata[7:0]);
                    errors++;
                end
                if (m_tdata[13:8] !== e.pos)
                begin
                    $display("%0t: position expected %0d actual %0d", $realtime, e.pos,
                             m_tdata[13:8]);
                    errors++;
                end
                if (m_tlast !== e.last)
                begin
                    $display("%0t: last expected %b actual %b", $realtime, e.last, m_tlast);
                    errors++;
                end
                if (m_tuser !== e.outside)
                begin
                    $display("%0t: outside expected %b actual %b", $realtime, e.outside, m_tuser);
                    errors++;
                end
            end
        end
    end

    // Result-side backpressure in random bursts.
    always @(posedge clk)
    begin
        if (rdy_hold == 0 && idle_en && $urandom_range(0, 7) == 0)
            rdy_hold = $urandom_range(1, 15);
        if (rdy_hold > 0)
        begin
            m_tready <= 1'b0;
            rdy_hold--;
        end
        else
            m_tready <= 1'b1;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial
    begin
        logic [APB_DW-1:0] widths  [6];
        logic [APB_DW-1:0] heights [6];
        int per_phase;
        errors = 0;
        cycles = 0;
        rdy_hold = 0;
        idle_en = 1;
        frame_w = int'(FRAME_WIDTH_RST);
        frame_h = int'(FRAME_HEIGHT_RST);
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = 1'b0;
        m_tready = 1'b1;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        // Smallest picture, widest register values that clamp to the maximum,
        // values below sixteen, values that round down, and a wide flat picture.
        widths  = '{32'd16, 32'hFFFF_FFFF, 32'd0, 32'd48, 32'd100, 32'd1024};
        heights = '{32'd16, 32'd2047, 32'd5, 32'd32, 32'd40, 32'd16};

        // Directed rows under the reset picture size of 720x576 (45 macroblocks wide).
        // An untouched store predicts zero everywhere.
        directed_items.push_back(mk(MODE_PRED, 0, 0, 0, 0, 0, 0, 1, 0, 0));
        directed_items.push_back(mk(MODE_WRITE, 0, 0, 0, 255, 0, 0, 0, 0, 0));
        directed_items.push_back(mk(MODE_WRITE, 0, 0, 1, 128, 0, 0, 0, 0, 0));
        directed_items.push_back(mk(MODE_WRITE, 0, 0, 8, 7, 0, 0, 0, 0, 0));
        directed_items.push_back(mk(MODE_WRITE, 0, 0, 9, 1, 0, 0, 0, 0, 0));
        directed_items.push_back(mk(MODE_WRITE, 0, 0, 63, 200, 0, 0, 0, 0, 0));
        directed_items.push_back(mk(MODE_PRED, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        directed_items.push_back(mk(MODE_PRED, 0, 0, 0, 0, 1, 0, 0, 0, 0));
        directed_items.push_back(mk(MODE_PRED, 0, 0, 0, 0, 0, 1, 0, 0, 0));
        directed_items.push_back(mk(MODE_PRED, 0, 0, 0, 0, 1, 1, 0, 0, 0));
        directed_items.push_back(mk(MODE_PRED, 0, 0, 0, 0, -1, -1, 0, 0, 0));
        directed_items.push_back(mk(MODE_WRITE, 0, BLK_CB, 0, 90, 0, 0, 0, 0, 0));
        directed_items.push_back(mk(MODE_WRITE, 0, BLK_CR, 9, 33, 0, 0, 0, 0, 0));
        // Chroma halves the vector toward zero: 3 becomes 1, -3 becomes -1.
        directed_items.push_back(mk(MODE_PRED, 0, BLK_CB, 0, 0, 3, 3, 0, 0, 0));
        directed_items.push_back(mk(MODE_PRED, 0, BLK_CR, 0, 0, -3, -3, 0, 0, 0));
        // Block select six is an ignored write, seven a prediction with no results.
        directed_items.push_back(mk(MODE_WRITE, 0, 6, 0, 255, 0, 0, 0, 0, 0));
        directed_items.push_back(mk(MODE_PRED, 0, 7, 0, 0, 0, 0, 0, 0, 0));
        // A macroblock below the picture: the write is dropped and the prediction
        // clamps onto the never-written bottom row of the picture.
        directed_items.push_back(mk(MODE_WRITE, 4095, 3, 63, 255, 0, 0, 0, 0, 0));
        directed_items.push_back(mk(MODE_PRED, 4095, 3, 0, 0, 0, 0, 1, 0, 1));
        directed_items.push_back(mk(MODE_PRED, 0, 3, 0, 0, -4096, -4096, 0, 0, 0));
        directed_items.push_back(mk(MODE_PRED, 0, 3, 0, 0, 4095, 4095, 0, 0, 0));
        // A right-edge block, where horizontal interpolation is switched off, and a bottom-right block, where both are.
        directed_items.push_back(mk(MODE_WRITE, 44, 1, 7, 77, 0, 0, 0, 0, 0));
        directed_items.push_back(mk(MODE_PRED, 44, 1, 0, 0, 1, 1, 0, 0, 0));
        directed_items.push_back(mk(MODE_PRED, 1619, 3, 0, 0, 1, 1, 0, 0, 0));

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        foreach (directed_items[i])
            send_item(directed_items[i]);

        // Hold off the sender until everything predicted so far has come out.
        wait_idle();

        per_phase = 24;
        for (int ph = 0; ph < 6; ph++)
        begin
            reg_write(ADDR_WIDTH, widths[ph]);
            reg_write(ADDR_HEIGHT, heights[ph]);
            // One phase runs without any idling on either side.
            idle_en = (ph != 3);
            for (int i = 0; i < per_phase; i++)
            begin
                if (ph == 5 && i >= per_phase - 10) idle_en = 0;
                send_item(rand_item());
            end
            wait_idle();
        end

        reg_write(ADDR_WIDTH, 32'd720);
        reg_write(ADDR_HEIGHT, 32'd576);
        for (int i = 0; i < 10; i++)
            send_item(rand_item());
        wait_idle();
        repeat (100) @(posedge clk);

        if (errors == 0 && pending_samples.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule
